@@ hdl/bbt_pkg.sv @@
// Shared constants for the bar/beat/tick timebase: field widths,
// configuration register indexes and their reset values. No dependencies.
`default_nettype none

package bbt_pkg;

    localparam int TEMPO_W  = 17;
    localparam int BPB_W    = 6;
    localparam int UNIT_W   = 6;
    localparam int TPB_W    = 16;
    localparam int RATE_W   = 18;
    localparam int FRAME_W  = 32;
    localparam int PERIOD_W = 14;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int BAR_W    = 32;
    localparam int BFT_W    = 53;
    localparam int OFF_W    = 24;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 144;

    localparam logic [CFG_IDX_W-1:0] REG_TEMPO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TPB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 3'd4;

    localparam logic [TEMPO_W-1:0] TEMPO_RST = 17'd30720;
    localparam logic [BPB_W-1:0]   BPB_RST   = 6'd4;
    localparam logic [UNIT_W-1:0]  UNIT_RST  = 6'd4;
    localparam logic [TPB_W-1:0]   TPB_RST   = 16'd1920;
    localparam logic [RATE_W-1:0]  RATE_RST  = 18'd48000;

    localparam logic [23:0] SECONDS_PER_MIN = 24'd60;

endpackage

`default_nettype wire

@@ hdl/bar_beat_tick_position_generator_core.sv @@
// Bar/beat/tick timebase top level: one shared multiplier and one radix-2
// divider under a sequencer. Depends on bbt_pkg.
`default_nettype none

// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      s_tdata, s_tuser
// m_*      out  m_tvalid / m_tready      m_tdata
// cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each word runs through the serial divider, one quotient bit per cycle over
// 48 + 32 + 32 + 55 bits, plus 64 when a relocation breaks continuity and the
// position does not saturate; the 32-bit offset division is skipped at zero
// tempo. Reset clears the position, the last frame and the registers to their
// defaults. A stalled output holds its word and the next input word is taken
// once the result has moved into the output register.

module bar_beat_tick_position_generator_core
    import bbt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // frame_position, period_frames
    input  wire logic                 s_tuser,   // relocated
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // bar_number, beat_in_bar,
                                                 // tick_in_beat, bar_first_tick,
                                                 // tick_frame_offset, beat_unit_echo
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_FPM, S_TT, S_RELOC, S_RDIV, S_FRAC, S_WHOLE, S_WTICK, S_DIV,
        S_BFT1, S_BFT2, S_BFT3, S_OFF2, S_INC1, S_INC2, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RET_RELOC, RET_TICK, RET_BAR, RET_OFF, RET_INC
    } div_ret_t;

    logic [TEMPO_W-1:0] tempo_reg;
    logic [BPB_W-1:0]   bpb_reg;
    logic [UNIT_W-1:0]  unit_reg;
    logic [TPB_W-1:0]   tpb_reg;
    logic [RATE_W-1:0]  rate_reg;

    logic [BPB_W-1:0]  bpb_nz;
    logic [TPB_W-1:0]  tpb_nz;
    logic [RATE_W-1:0] rate_nz;

    state_t state_reg, state_next;
    div_ret_t ret_reg, ret_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                reloc_reg, reloc_next;
    logic [FRAME_W-1:0]  prev_reg, prev_next;
    logic [63:0]         pos_reg, pos_next;
    logic [61:0]         prod_reg, prod_next;
    logic [23:0]         fpm_reg, fpm_next;
    logic [32:0]         tt_reg, tt_next;
    logic [31:0]         ftick_reg, ftick_next;
    logic [15:0]         lphi_reg, lphi_next;
    logic [BAR_W-1:0]    bar_reg, bar_next;
    logic [BPB_W-1:0]    beat_reg, beat_next;
    logic [TPB_W-1:0]    tick_reg, tick_next;
    logic [BFT_W-1:0]    bft_reg, bft_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [32:0]         rem_reg, rem_next;
    logic [63:0]         dd_reg, dd_next;
    logic [63:0]         q_reg, q_next;
    logic [32:0]         dvs_reg, dvs_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [37:0] mul_a;
    logic [23:0] mul_b;
    logic [33:0] div_t;
    logic        div_ge;
    logic [32:0] rem_step;
    logic [63:0] q_step;
    logic [47:0] wticks;
    logic [64:0] pos_sum;

    assign bpb_nz  = (bpb_reg == '0)  ? BPB_W'(1)  : bpb_reg;
    assign tpb_nz  = (tpb_reg == '0)  ? TPB_W'(1)  : tpb_reg;
    assign rate_nz = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg <= TEMPO_RST;
            bpb_reg   <= BPB_RST;
            unit_reg  <= UNIT_RST;
            tpb_reg   <= TPB_RST;
            rate_reg  <= RATE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEMPO: tempo_reg <= cfg_data[TEMPO_W-1:0];
                REG_BPB:   bpb_reg   <= cfg_data[BPB_W-1:0];
                REG_UNIT:  unit_reg  <= cfg_data[UNIT_W-1:0];
                REG_TPB:   tpb_reg   <= cfg_data[TPB_W-1:0];
                REG_RATE:  rate_reg  <= cfg_data[RATE_W-1:0];
                default:   ;
            endcase
        end
    end

    assign div_t    = {rem_reg, dd_reg[63]};
    assign div_ge   = div_t >= {1'b0, dvs_reg};
    assign rem_step = div_ge ? 33'(div_t - {1'b0, dvs_reg}) : div_t[32:0];
    assign q_step   = {q_reg[62:0], div_ge};
    assign wticks   = prod_reg[47:0] + {32'b0, lphi_reg};
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, q_step};

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        frame_next    = frame_reg;
        period_next   = period_reg;
        reloc_next    = reloc_reg;
        prev_next     = prev_reg;
        pos_next      = pos_reg;
        fpm_next      = fpm_reg;
        tt_next       = tt_reg;
        ftick_next    = ftick_reg;
        lphi_next     = lphi_reg;
        bar_next      = bar_reg;
        beat_next     = beat_reg;
        tick_next     = tick_reg;
        bft_next      = bft_reg;
        off_next      = off_reg;
        rem_next      = rem_reg;
        dd_next       = dd_reg;
        q_next        = q_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        m_data_next   = m_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mul_a         = '0;
        mul_b         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    frame_next  = s_tdata[31:0];
                    period_next = s_tdata[45:32];
                    reloc_next  = s_tuser;
                    state_next  = S_FPM;
                end
            end
            S_FPM:
            begin
                mul_a      = {20'b0, rate_nz};
                mul_b      = SECONDS_PER_MIN;
                state_next = S_TT;
            end
            S_TT:
            begin
                fpm_next   = prod_reg[23:0];
                mul_a      = {21'b0, tempo_reg};
                mul_b      = {8'b0, tpb_nz};
                state_next = S_RELOC;
            end
            S_RELOC:
            begin
                tt_next   = prod_reg[32:0];
                prev_next = frame_reg;
                mul_a     = {6'b0, frame_reg};
                mul_b     = {7'b0, tempo_reg};
                if (reloc_reg && (32'(prev_reg + 32'(period_reg)) != frame_reg))
                    state_next = S_RDIV;
                else
                    state_next = S_FRAC;
            end
            S_RDIV:
            begin
                if ({15'b0, prod_reg[48:40]} >= fpm_reg)
                begin
                    pos_next   = '1;
                    state_next = S_FRAC;
                end
                else
                begin
                    rem_next   = {24'b0, prod_reg[48:40]};
                    dd_next    = {prod_reg[39:0], 24'b0};
                    q_next     = '0;
                    dvs_next   = {9'b0, fpm_reg};
                    cnt_next   = 7'd64;
                    ret_next   = RET_RELOC;
                    state_next = S_DIV;
                end
            end
            S_FRAC:
            begin
                mul_a      = {6'b0, pos_reg[31:0]};
                mul_b      = {8'b0, tpb_nz};
                state_next = S_WHOLE;
            end
            S_WHOLE:
            begin
                ftick_next = prod_reg[31:0];
                lphi_next  = prod_reg[47:32];
                mul_a      = {6'b0, pos_reg[63:32]};
                mul_b      = {8'b0, tpb_nz};
                state_next = S_WTICK;
            end
            S_WTICK:
            begin
                rem_next   = '0;
                dd_next    = {wticks, 16'b0};
                q_next     = '0;
                dvs_next   = {17'b0, tpb_nz};
                cnt_next   = 7'd48;
                ret_next   = RET_TICK;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = rem_step;
                dd_next  = {dd_reg[62:0], 1'b0};
                q_next   = q_step;
                cnt_next = 7'(cnt_reg - 7'd1);
                if (cnt_reg == 7'd1)
                begin
                    unique case (ret_reg)
                        RET_RELOC:
                        begin
                            pos_next   = q_step;
                            state_next = S_FRAC;
                        end
                        RET_TICK:
                        begin
                            tick_next = rem_step[15:0];
                            rem_next  = '0;
                            dd_next   = {pos_reg[63:32], 32'b0};
                            q_next    = '0;
                            dvs_next  = {27'b0, bpb_nz};
                            cnt_next  = 7'd32;
                            ret_next  = RET_BAR;
                        end
                        RET_BAR:
                        begin
                            bar_next   = (q_step[31:0] == '1) ? '1 : 32'(q_step[31:0] + 32'd1);
                            beat_next  = 6'(rem_step[5:0] + 6'd1);
                            state_next = S_BFT1;
                        end
                        RET_OFF:
                        begin
                            off_next   = (q_step[31:24] != '0) ? '1 : q_step[23:0];
                            state_next = S_INC1;
                        end
                        RET_INC:
                        begin
                            pos_next   = pos_sum[64] ? '1 : pos_sum[63:0];
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_BFT1:
            begin
                mul_a      = {6'b0, 32'(bar_reg - 32'd1)};
                mul_b      = {18'b0, bpb_nz};
                state_next = S_BFT2;
            end
            S_BFT2:
            begin
                mul_a      = prod_reg[37:0];
                mul_b      = {8'b0, tpb_nz};
                state_next = S_BFT3;
            end
            S_BFT3:
            begin
                bft_next   = prod_reg[52:0];
                mul_a      = {6'b0, ftick_reg};
                mul_b      = fpm_reg;
                state_next = S_OFF2;
            end
            S_OFF2:
            begin
                if (tempo_reg == '0)
                begin
                    off_next   = '0;
                    state_next = S_INC1;
                end
                else
                begin
                    rem_next   = '0;
                    dd_next    = {prod_reg[55:24], 32'b0};
                    q_next     = '0;
                    dvs_next   = tt_reg;
                    cnt_next   = 7'd32;
                    ret_next   = RET_OFF;
                    state_next = S_DIV;
                end
            end
            S_INC1:
            begin
                mul_a      = {24'b0, period_reg};
                mul_b      = {7'b0, tempo_reg};
                state_next = S_INC2;
            end
            S_INC2:
            begin
                rem_next   = '0;
                dd_next    = {prod_reg[30:0], 33'b0};
                q_next     = '0;
                dvs_next   = {9'b0, fpm_reg};
                cnt_next   = 7'd55;
                ret_next   = RET_INC;
                state_next = S_DIV;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_data_next   = {7'b0, unit_reg, off_reg, bft_reg, tick_reg,
                                     beat_reg, bar_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = {24'b0, mul_a} * {38'b0, mul_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= RET_RELOC;
            prev_reg     <= '0;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            prev_reg     <= prev_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        period_reg <= period_next;
        reloc_reg  <= reloc_next;
        prod_reg   <= prod_next;
        fpm_reg    <= fpm_next;
        tt_reg     <= tt_next;
        ftick_reg  <= ftick_next;
        lphi_reg   <= lphi_next;
        bar_reg    <= bar_next;
        beat_reg   <= beat_next;
        tick_reg   <= tick_next;
        bft_reg    <= bft_next;
        off_reg    <= off_next;
        rem_reg    <= rem_next;
        dd_reg     <= dd_next;
        q_reg      <= q_next;
        dvs_reg    <= dvs_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in progress");

    a_beat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[37:32] != '0)
        else $error("beat_in_bar is zero");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[53:38] < tpb_nz)
        else $error("tick_in_beat out of range");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg != '0)
        else $error("divider running with zero count");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the bar/beat/tick timebase core: a queue-fed
// stream driver, a result monitor and an in-bench predictor of the timebase.
// Depends on bbt_pkg and bar_beat_tick_position_generator_core.
`default_nettype none

module testbench;
    import bbt_pkg::*;

    typedef struct packed {
        logic [31:0] frame;
        logic [13:0] period;
        logic        reloc;
    } period_word_t;

    typedef struct {
        logic [31:0] bar;
        logic [5:0]  beat;
        logic [15:0] tick;
        logic [52:0] bar_tick;
        logic [23:0] offset;
        logic [5:0]  unit;
    } timebase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    period_word_t pending_words[$];
    timebase_t expected_positions[$];

    logic [63:0] tempo_r, bpb_r, unit_r, tpb_r, rate_r;
    logic [63:0] position_q32;
    logic [31:0] last_frame;

    int errors = 0;
    int words_checked = 0;
    int words_queued = 0;
    int settings_run = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int stall_gap = 0;
    logic [31:0] next_frame = '0;

    bar_beat_tick_position_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (quiet || r < 50)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 20));
        else
            return int'($urandom_range(30, 200));
    endfunction

    function automatic timebase_t step_timebase(period_word_t w);
        logic [63:0] rate, bpb, tpb, fpm, prod, whole, low, ticks, frac, bar, num, quo, inc;
        logic [127:0] wide;
        timebase_t o;
        rate = (rate_r == 0) ? 64'd1 : rate_r;
        bpb = (bpb_r == 0) ? 64'd1 : bpb_r;
        tpb = (tpb_r == 0) ? 64'd1 : tpb_r;
        fpm = rate * 64'd60;
        if (w.reloc && (last_frame + 32'(w.period)) != w.frame)
        begin
            prod = 64'(w.frame) * tempo_r;
            wide = {64'd0, prod} << 24;
            wide = wide / {64'd0, fpm};
            position_q32 = (wide[127:64] != 0) ? '1 : wide[63:0];
        end
        last_frame = w.frame;
        whole = position_q32 >> 32;
        low = {32'd0, position_q32[31:0]} * tpb;
        ticks = whole * tpb + (low >> 32);
        frac = {32'd0, low[31:0]};
        bar = whole / bpb + 64'd1;
        if (bar > 64'hFFFF_FFFF)
            bar = 64'hFFFF_FFFF;
        if (tempo_r == 0)
            o.offset = '0;
        else
        begin
            num = frac * (fpm * 64'd256);
            quo = (num / (tempo_r * tpb)) >> 32;
            o.offset = (quo > 64'hFF_FFFF) ? 24'hFF_FFFF : quo[23:0];
        end
        o.bar = bar[31:0];
        o.beat = 6'(whole % bpb + 64'd1);
        o.tick = 16'(ticks % tpb);
        o.bar_tick = 53'((bar - 64'd1) * bpb * tpb);
        o.unit = unit_r[5:0];
        inc = ((64'(w.period) * tempo_r) << 24) / fpm;
        if (position_q32 > ~inc)
            position_q32 = '1;
        else
            position_q32 = position_q32 + inc;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_r <= 64'(TEMPO_RST);
            bpb_r <= 64'(BPB_RST);
            unit_r <= 64'(UNIT_RST);
            tpb_r <= 64'(TPB_RST);
            rate_r <= 64'(RATE_RST);
            position_q32 = '0;
            last_frame = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TEMPO: tempo_r <= 64'(cfg_data[TEMPO_W-1:0]);
                    REG_BPB:   bpb_r <= 64'(cfg_data[BPB_W-1:0]);
                    REG_UNIT:  unit_r <= 64'(cfg_data[UNIT_W-1:0]);
                    REG_TPB:   tpb_r <= 64'(cfg_data[TPB_W-1:0]);
                    REG_RATE:  rate_r <= 64'(cfg_data[RATE_W-1:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_positions.push_back(
                    step_timebase({s_tdata[31:0], s_tdata[45:32], s_tuser}));
        end
    end

    // drive input words, hold until taken
    always @(posedge clk or negedge rst_n)
    begin
        period_word_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                w = pending_words.pop_front();
                s_tdata <= {2'b00, w.period, w.frame};
                s_tuser <= w.reloc;
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_gap > 0)
        begin
            stall_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_gap = pick_gap();
        end
    end

    // check result words against the oldest prediction
    always @(posedge clk)
    begin
        timebase_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_positions.size() == 0)
            begin
                $error("result word with no prediction pending");
                errors++;
            end
            else
            begin
                e = expected_positions.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== e.bar)
                begin
                    $error("bar_number expected %0d actual %0d", e.bar, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[37:32] !== e.beat)
                begin
                    $error("beat_in_bar expected %0d actual %0d", e.beat, m_tdata[37:32]);
                    errors++;
                end
                if (m_tdata[53:38] !== e.tick)
                begin
                    $error("tick_in_beat expected %0d actual %0d", e.tick, m_tdata[53:38]);
                    errors++;
                end
                if (m_tdata[106:54] !== e.bar_tick)
                begin
                    $error("bar_first_tick expected %0d actual %0d", e.bar_tick,
                           m_tdata[106:54]);
                    errors++;
                end
                if (m_tdata[130:107] !== e.offset)
                begin
                    $error("tick_frame_offset expected %0d actual %0d", e.offset,
                           m_tdata[130:107]);
                    errors++;
                end
                if (m_tdata[136:131] !== e.unit)
                begin
                    $error("beat_unit_echo expected %0d actual %0d", e.unit, m_tdata[136:131]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timebase(logic [CFG_W-1:0] tempo, logic [CFG_W-1:0] bpb,
                                logic [CFG_W-1:0] unit, logic [CFG_W-1:0] tpb,
                                logic [CFG_W-1:0] rate);
        write_reg(REG_TEMPO, tempo);
        write_reg(REG_BPB, bpb);
        write_reg(REG_UNIT, unit);
        write_reg(REG_TPB, tpb);
        write_reg(REG_RATE, rate);
        settings_run++;
    endtask

    task automatic push_word(logic [31:0] frame, logic [13:0] period, logic reloc);
        pending_words.push_back('{frame, period, reloc});
        words_queued++;
        next_frame = frame + 32'(period);
    endtask

    // hold until every queued word has come back and been checked
    task automatic drain();
        while (words_checked < words_queued)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic push_random_words(int count);
        int k;
        logic [13:0] period;
        for (k = 0; k < count; k++)
        begin
            period = ($urandom_range(0, 15) == 0) ? 14'($urandom)
                                                  : 14'($urandom_range(1, 8192));
            case ($urandom_range(0, 9))
                0: push_word($urandom, 14'($urandom_range(1, 8192)), 1'b1);
                1: push_word($urandom, 14'($urandom), 1'($urandom));
                default: push_word(next_frame, period, $urandom_range(0, 9) == 0);
            endcase
        end
    endtask

    initial
    begin
        int total;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        settings_run = 1;

        // reset settings: continuity, wraparound, period extremes
        push_word(32'd0, 14'd1, 1'b0);
        push_word(32'd1, 14'd0, 1'b1);
        push_word(32'd1, 14'd512, 1'b1);
        push_word(32'd4800000, 14'd16383, 1'b1);
        push_word(next_frame, 14'd256, 1'b0);
        push_word(32'hFFFF_FFF0, 14'd32, 1'b1);
        push_word(32'h0000_0010, 14'd100, 1'b1);
        push_word(32'hFFFF_FFFF, 14'd8192, 1'b1);
        drain();

        // zero rate, bar and tick counts with top tempo: position saturates
        set_timebase(18'd131071, 18'd0, 18'd63, 18'd0, 18'd0);
        push_word(32'hFFFF_FFFF, 14'd1, 1'b1);
        push_word(next_frame, 14'd16383, 1'b1);
        push_word(32'd5, 14'd1, 1'b1);
        push_word(next_frame, 14'd8192, 1'b0);
        drain();

        // zero tempo: position frozen, relocation clears it
        set_timebase(18'd0, 18'd63, 18'd0, 18'd65535, 18'd262143);
        push_word(32'd123456, 14'd64, 1'b1);
        push_word(next_frame, 14'd64, 1'b0);
        push_word(32'd77, 14'd64, 1'b1);
        drain();

        set_timebase(18'd256, 18'd1, 18'd1, 18'd1, 18'd8000);
        push_word(32'd96000, 14'd8192, 1'b1);
        push_word(next_frame, 14'd1, 1'b0);
        push_word(next_frame, 14'd8192, 1'b0);
        drain();

        set_timebase(18'd76800, 18'd32, 18'd32, 18'd65535, 18'd192000);
        push_word(32'hFFFF_FFFF, 14'd8192, 1'b1);
        push_word(next_frame, 14'd8192, 1'b0);
        push_word(32'd1000, 14'd8192, 1'b1);
        drain();

        total = 0;
        while (total < 1600)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0)
                set_timebase(18'($urandom), 18'($urandom), 18'($urandom),
                             18'($urandom), 18'($urandom));
            else
                set_timebase(18'($urandom_range(256, 76800)), 18'($urandom_range(1, 32)),
                             18'($urandom_range(1, 32)),
                             ($urandom_range(0, 1) == 0) ? 18'($urandom_range(1, 1920))
                                                         : 18'($urandom_range(1, 65535)),
                             18'($urandom_range(8000, 192000)));
            n = int'($urandom_range(20, 80));
            push_random_words(n);
            total += n;
            drain();
        end

        repeat (300) @(posedge clk);
        $display("run covered %0d result words over %0d register settings",
                 words_checked, settings_run);
        if (errors == 0 && expected_positions.size() == 0 && words_checked == words_queued)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/bbt_pkg.sv
hdl/bar_beat_tick_position_generator_core.sv
tb/sv/testbench.sv
